// ----- src/chol_pkg.sv -----
package chol_pkg;

    localparam int MAX_ORDER_DEF = 16;
    localparam int IDX_W         = 6;
    localparam int SIZE_W        = 5;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    typedef enum logic [1:0] {
        KIND_MATRIX = 2'd0,
        KIND_VECTOR = 2'd1,
        KIND_SOLVE  = 2'd2
    } in_kind_t;

    typedef enum logic [1:0] {
        RES_OK         = 2'd0,
        RES_NPD        = 2'd1,
        RES_ZERO_PIVOT = 2'd2
    } res_status_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_ACC_ZERO,
        DP_ACC_V,
        DP_ACC_Z,
        DP_MUL_M,
        DP_MUL_Z,
        DP_RND,
        DP_ADD,
        DP_SUB,
        DP_SQRT,
        DP_DIV_OFF,
        DP_DIV_SOL,
        DP_WR_ROOT,
        DP_WR_QM,
        DP_WR_QZ,
        DP_OUT_SOL,
        DP_OUT_ERR
    } dp_op_t;

    typedef enum logic [1:0] {
        PH_DIAG,
        PH_OFF,
        PH_FWD,
        PH_BACK
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ACC,
        ST_T_RD,
        ST_T_MUL,
        ST_T_RND,
        ST_T_ACC,
        ST_P_RD,
        ST_P_USE,
        ST_WAIT,
        ST_WRITE,
        ST_E_RD,
        ST_E_OUT,
        ST_ERR
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t           op;
        logic [IDX_W-1:0] a_row;
        logic [IDX_W-1:0] a_col;
        logic [IDX_W-1:0] b_row;
        logic [IDX_W-1:0] b_col;
        logic [IDX_W-1:0] vz_addr;
        logic [IDX_W-1:0] out_index;
        logic [1:0]       out_status;
        logic             out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic npd;
        logic root_zero;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ----- src/chol_div.sv -----
module chol_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic        [31:0] divisor,
    output logic               done,
    output logic signed [31:0] quot
);
    import chol_pkg::*;

    localparam int NW = 48;

    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] q_reg, q_next;
    logic [32:0]   rem_reg, rem_next;
    logic [31:0]   den_reg, den_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          neg_reg, neg_next;
    logic [32:0]   rem_t;
    logic [32:0]   mag;
    logic signed [63:0] qs;

    always_comb begin
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        mag       = dividend[31] ? (33'd0 - {dividend[31], dividend}) : {1'b0, dividend};
        rem_t     = {rem_reg[31:0], num_reg[NW-1]};
        if (start) begin
            num_next  = {mag[31:0], 16'd0};
            q_next    = '0;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            neg_next  = dividend[31];
        end else if (busy_reg) begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (rem_t >= {1'b0, den_reg}) begin
                rem_next = rem_t - {1'b0, den_reg};
                q_next   = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = rem_t;
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg <= num_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign qs   = neg_reg ? -$signed({16'd0, q_reg}) : $signed({16'd0, q_reg});
    assign quot = sat32(qs);
    assign done = done_reg;

endmodule

// ----- src/chol_sqrt.sv -----
module chol_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import chol_pkg::*;

    localparam int VW    = 48;
    localparam int STEPS = VW / 2;

    logic [VW-1:0] v_reg, v_next;
    logic [VW-1:0] r_reg, r_next;
    logic [VW-1:0] bit_reg, bit_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW-1:0] sum;

    always_comb begin
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sum       = r_reg + bit_reg;
        if (start) begin
            v_next    = {radicand, 16'd0};
            r_next    = '0;
            bit_next  = VW'(1) << (VW - 2);
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (v_reg >= sum) begin
                v_next = v_reg - sum;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
        cnt_reg <= cnt_next;
    end

    assign root = r_reg[31:0];
    assign done = done_reg;

endmodule

// ----- src/chol_dp.sv -----
module chol_dp #(
    parameter int MAX_ORDER = chol_pkg::MAX_ORDER_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  chol_pkg::dp_cmd_t cmd,
    output chol_pkg::dp_stat_t stat,
    input  logic [1:0]        in_kind,
    input  logic [3:0]        in_row,
    input  logic [3:0]        in_col,
    input  logic [31:0]       in_value,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import chol_pkg::*;

    localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] mem_m [DEPTH];
    logic [31:0] mem_v [MAX_ORDER];
    logic [31:0] mem_z [MAX_ORDER];

    logic signed [31:0] ma_rd, mb_rd, v_rd, z_rd;
    logic signed [31:0] acc_reg, term_reg, d_reg;
    logic signed [63:0] prod_reg;
    logic               out_valid_reg;
    logic [3:0]         out_index_reg;
    logic [31:0]        out_sol_reg;
    logic [1:0]         out_status_reg;
    logic               out_last_reg;

    logic [AW-1:0] a_addr, b_addr, in_addr, wm_addr;
    logic [IW-1:0] vz_addr;
    logic          in_bounds;
    logic          wm_en;
    logic [31:0]   wm_data;
    logic signed [31:0] diff;
    logic signed [31:0] quot;
    logic [31:0]   root;
    logic          sqrt_done, div_done;
    logic          sqrt_start, div_start;
    logic signed [31:0] div_num;
    logic [31:0]   div_den;
    logic signed [63:0] rounded;

    assign a_addr  = AW'(32'(cmd.a_row[IW-1:0]) * MAX_ORDER + 32'(cmd.a_col[IW-1:0]));
    assign b_addr  = AW'(32'(cmd.b_row[IW-1:0]) * MAX_ORDER + 32'(cmd.b_col[IW-1:0]));
    assign in_addr = AW'(32'(in_row) * MAX_ORDER + 32'(in_col));
    assign vz_addr = cmd.vz_addr[IW-1:0];
    assign in_bounds = (32'(in_row) < MAX_ORDER) && (32'(in_col) < MAX_ORDER);

    always_comb begin
        wm_en   = 1'b0;
        wm_addr = a_addr;
        wm_data = quot;
        case (cmd.op)
            DP_LOAD: begin
                wm_en   = (in_kind == KIND_MATRIX) && in_bounds;
                wm_addr = in_addr;
                wm_data = in_value;
            end
            DP_WR_ROOT: begin
                wm_en   = 1'b1;
                wm_data = root;
            end
            DP_WR_QM: begin
                wm_en = 1'b1;
            end
            default: begin
                wm_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wm_en) begin
            mem_m[wm_addr] <= wm_data;
        end
        ma_rd <= mem_m[a_addr];
        mb_rd <= mem_m[b_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_LOAD && in_kind == KIND_VECTOR && 32'(in_row) < MAX_ORDER) begin
            mem_v[IW'(in_row)] <= in_value;
        end
        v_rd <= mem_v[vz_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_WR_QZ) begin
            mem_z[vz_addr] <= quot;
        end
        z_rd <= mem_z[vz_addr];
    end

    assign diff    = sat32(64'(ma_rd) - 64'(acc_reg));
    assign rounded = (prod_reg + 64'sd32768) >>> 16;

    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_ACC_ZERO: acc_reg <= '0;
            DP_ACC_V:    acc_reg <= v_rd;
            DP_ACC_Z:    acc_reg <= z_rd;
            DP_ADD:      acc_reg <= sat32(64'(acc_reg) + 64'(term_reg));
            DP_SUB:      acc_reg <= sat32(64'(acc_reg) - 64'(term_reg));
            default:     acc_reg <= acc_reg;
        endcase
        if (cmd.op == DP_MUL_M) begin
            prod_reg <= 64'(ma_rd) * 64'(mb_rd);
        end else if (cmd.op == DP_MUL_Z) begin
            prod_reg <= 64'(ma_rd) * 64'(z_rd);
        end
        if (cmd.op == DP_RND) begin
            term_reg <= sat32(rounded);
        end
        if (cmd.op == DP_WR_ROOT) begin
            d_reg <= root;
        end
    end

    assign sqrt_start = (cmd.op == DP_SQRT);
    assign div_start  = (cmd.op == DP_DIV_OFF) || (cmd.op == DP_DIV_SOL);
    assign div_num    = (cmd.op == DP_DIV_OFF) ? diff : acc_reg;
    assign div_den    = (cmd.op == DP_DIV_OFF) ? d_reg : ma_rd;

    chol_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (diff),
        .done     (sqrt_done),
        .root     (root)
    );

    chol_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quot     (quot)
    );

    // hold the result item until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == DP_OUT_SOL || cmd.op == DP_OUT_ERR) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.op == DP_OUT_SOL || cmd.op == DP_OUT_ERR) begin
            out_index_reg  <= cmd.out_index[3:0];
            out_sol_reg    <= (cmd.op == DP_OUT_SOL) ? z_rd : 32'd0;
            out_status_reg <= cmd.out_status;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign stat.npd       = (ma_rd < acc_reg);
    assign stat.root_zero = (root == 32'd0);
    assign stat.sqrt_done = sqrt_done;
    assign stat.div_done  = div_done;
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_sol_reg, out_index_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- src/chol_ctrl.sv -----
module chol_ctrl #(
    parameter int MAX_ORDER = chol_pkg::MAX_ORDER_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         s_tuser,
    input  chol_pkg::dp_stat_t stat,
    output chol_pkg::dp_cmd_t  cmd
);
    import chol_pkg::*;

    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CW = $clog2(MAX_ORDER + 1);

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [1:0]    err_reg, err_next;
    logic [SIZE_W-1:0] size_reg;
    logic [CW-1:0] n_eff, k_start, k_end, i_inc, j_inc, k_inc;

    function automatic logic [IDX_W-1:0] to_idx(input logic [CW-1:0] v);
        return IDX_W'(v[IW-1:0]);
    endfunction

    always_comb begin
        if (size_reg == '0) begin
            n_eff = CW'(1);
        end else if (32'(size_reg) > MAX_ORDER) begin
            n_eff = CW'(MAX_ORDER);
        end else begin
            n_eff = CW'(size_reg);
        end
    end

    assign i_inc   = i_reg + CW'(1);
    assign j_inc   = j_reg + CW'(1);
    assign k_inc   = k_reg + CW'(1);
    assign k_start = (phase_reg == PH_BACK) ? i_inc : '0;
    assign k_end   = (phase_reg == PH_BACK) ? n_eff : i_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DIAG;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            err_reg   <= RES_OK;
            size_reg  <= SIZE_RESET;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            err_reg   <= err_next;
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        err_next   = err_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser == KIND_SOLVE) begin
                    phase_next = PH_DIAG;
                    i_next     = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT: state_next = ST_ACC;
            ST_ACC: begin
                k_next     = k_start;
                state_next = (k_start < k_end) ? ST_T_RD : ST_P_RD;
            end
            ST_T_RD:  state_next = ST_T_MUL;
            ST_T_MUL: state_next = ST_T_RND;
            ST_T_RND: state_next = ST_T_ACC;
            ST_T_ACC: begin
                k_next     = k_inc;
                state_next = (k_inc < k_end) ? ST_T_RD : ST_P_RD;
            end
            ST_P_RD: state_next = ST_P_USE;
            ST_P_USE: begin
                if (phase_reg == PH_DIAG && stat.npd) begin
                    err_next   = RES_NPD;
                    state_next = ST_ERR;
                end else begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if ((phase_reg == PH_DIAG) ? stat.sqrt_done : stat.div_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = ST_INIT;
                case (phase_reg)
                    PH_DIAG: begin
                        if (stat.root_zero) begin
                            err_next   = RES_ZERO_PIVOT;
                            state_next = ST_ERR;
                        end else if (i_inc < n_eff) begin
                            phase_next = PH_OFF;
                            j_next     = i_inc;
                        end else begin
                            phase_next = PH_FWD;
                            i_next     = '0;
                        end
                    end
                    PH_OFF: begin
                        if (j_inc < n_eff) begin
                            j_next = j_inc;
                        end else begin
                            phase_next = PH_DIAG;
                            i_next     = i_inc;
                        end
                    end
                    PH_FWD: begin
                        if (i_inc < n_eff) begin
                            i_next = i_inc;
                        end else begin
                            phase_next = PH_BACK;
                            i_next     = n_eff - CW'(1);
                        end
                    end
                    default: begin
                        if (i_reg == '0) begin
                            state_next = ST_E_RD;
                        end else begin
                            i_next = i_reg - CW'(1);
                        end
                    end
                endcase
            end
            ST_E_RD: state_next = ST_E_OUT;
            ST_E_OUT: begin
                if (stat.out_free) begin
                    if (i_inc == n_eff) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_inc;
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_ERR: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = (state_reg == ST_IDLE);
        cmd.op         = DP_NOP;
        cmd.a_row      = to_idx((phase_reg == PH_OFF) ? j_reg : i_reg);
        cmd.a_col      = to_idx(i_reg);
        cmd.b_row      = to_idx(i_reg);
        cmd.b_col      = to_idx(k_reg);
        cmd.vz_addr    = to_idx(i_reg);
        cmd.out_index  = to_idx(i_reg);
        cmd.out_status = RES_OK;
        cmd.out_last   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && (s_tuser == KIND_MATRIX || s_tuser == KIND_VECTOR)) begin
                    cmd.op = DP_LOAD;
                end
            end
            ST_ACC: begin
                case (phase_reg)
                    PH_FWD:  cmd.op = DP_ACC_V;
                    PH_BACK: cmd.op = DP_ACC_Z;
                    default: cmd.op = DP_ACC_ZERO;
                endcase
            end
            ST_T_RD: begin
                cmd.vz_addr = to_idx(k_reg);
                case (phase_reg)
                    PH_OFF: begin
                        cmd.a_row = to_idx(j_reg);
                        cmd.a_col = to_idx(k_reg);
                    end
                    PH_BACK: begin
                        cmd.a_row = to_idx(k_reg);
                        cmd.a_col = to_idx(i_reg);
                    end
                    default: begin
                        cmd.a_row = to_idx(i_reg);
                        cmd.a_col = to_idx(k_reg);
                    end
                endcase
            end
            ST_T_MUL: begin
                cmd.op = (phase_reg == PH_DIAG || phase_reg == PH_OFF) ? DP_MUL_M : DP_MUL_Z;
            end
            ST_T_RND: cmd.op = DP_RND;
            ST_T_ACC: begin
                cmd.op = (phase_reg == PH_DIAG || phase_reg == PH_OFF) ? DP_ADD : DP_SUB;
            end
            ST_P_USE: begin
                case (phase_reg)
                    PH_DIAG: cmd.op = stat.npd ? DP_NOP : DP_SQRT;
                    PH_OFF:  cmd.op = DP_DIV_OFF;
                    default: cmd.op = DP_DIV_SOL;
                endcase
            end
            ST_WRITE: begin
                case (phase_reg)
                    PH_DIAG: cmd.op = stat.root_zero ? DP_NOP : DP_WR_ROOT;
                    PH_OFF:  cmd.op = DP_WR_QM;
                    default: cmd.op = DP_WR_QZ;
                endcase
            end
            ST_E_OUT: begin
                if (stat.out_free) begin
                    cmd.op       = DP_OUT_SOL;
                    cmd.out_last = (i_inc == n_eff);
                end
            end
            ST_ERR: begin
                if (stat.out_free) begin
                    cmd.op         = DP_OUT_ERR;
                    cmd.out_status = err_reg;
                    cmd.out_last   = 1'b1;
                end
            end
            default: cmd.op = DP_NOP;
        endcase
    end

endmodule

// ----- src/cholesky_linear_solver_unit.sv -----
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid / s_tready  s_tuser kind, s_tdata row, col, value
// m_        out  m_tvalid / m_tready  m_tuser status, m_tdata index, solution, m_tlast last
// cfg_      in   cfg_wr_en            cfg_wr_data size_in_use
//
// Load items are taken while idle. A solve runs on one shared multiply-accumulate
// path, each inner-product term passing read, multiply, round and accumulate
// steps, a bit-serial square root per row and a bit-serial divider per divide;
// results then leave one at a time, read from the solution store and registered.
// aresetn is synchronous, active low, and sets the order to 16. s_tready is low
// for the whole solve; each result waits in the output register while m_tready is low.
module cholesky_linear_solver_unit #(
    parameter int MAX_ORDER = chol_pkg::MAX_ORDER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,   // size_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // row[3:0], col[7:4], value[39:8]
    input  logic [1:0]  s_tuser,       // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // index[3:0], solution[35:4], zero pad
    output logic [1:0]  m_tuser,       // status[1:0]
    output logic        m_tlast
);
    import chol_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    chol_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .stat        (stat),
        .cmd         (cmd)
    );

    chol_dp #(.MAX_ORDER(MAX_ORDER)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_kind  (s_tuser),
        .in_row   (s_tdata[3:0]),
        .in_col   (s_tdata[7:4]),
        .in_value (s_tdata[39:8]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef ASSERT_OFF
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != RES_OK) |-> m_tlast)
        else $error("error item without last");

    a_solve_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_SOLVE) |=> !s_tready)
        else $error("input taken right after solve item");

    a_units_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.sqrt_done && stat.div_done))
        else $error("square root and divider finished together");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_OUT_SOL || cmd.op == DP_OUT_ERR) |-> (!m_tvalid || m_tready))
        else $error("result item overwritten");
`endif

endmodule

// ----- tb/cholesky_linear_solver_unit_tb.sv -----
module cholesky_linear_solver_unit_tb;
    import chol_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ORDER_MAX = 16;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 60;
    localparam int ITEM_TARGET = 320;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct {
        logic [3:0]         index;
        logic signed [31:0] solution;
        res_status_t        status;
        logic               last;
    } sol_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    cholesky_linear_solver_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #4 aclk = ~aclk;

    // predictor state
    logic signed [31:0] mat_model [ORDER_MAX][ORDER_MAX];
    logic signed [31:0] vec_model [ORDER_MAX];
    logic [4:0]         order_reg = 5'd16;
    sol_result_t        pending_solutions [$];

    int items_sent = 0;
    int solves_sent = 0;
    int results_seen = 0;
    int error_results = 0;
    int fail_count = 0;
    int send_gap_pct = 0;
    int stall_pct = 0;
    bit hold_output = 1'b0;
    int idle_cycles = 0;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return Q_MAX;
        if (v < -64'sd2147483648) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return clamp32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] d);
        longint num;
        num = longint'(a) * 64'sd65536;
        return clamp32(num / longint'(d));
    endfunction

    function automatic logic signed [31:0] fx_sqrt(logic signed [31:0] x);
        longint unsigned v, r, b;
        v = longint'({32'd0, x}) << 16;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic int order_in_use();
        if (order_reg < 1) return 1;
        if (order_reg > ORDER_MAX) return ORDER_MAX;
        return order_reg;
    endfunction

    function automatic void push_result(int idx, logic signed [31:0] v, res_status_t st, bit lst);
        sol_result_t r;
        r.index = idx[3:0];
        r.solution = v;
        r.status = st;
        r.last = lst;
        pending_solutions.push_back(r);
    endfunction

    // factor in place, then forward and back substitution
    function automatic void predict_solution();
        int n;
        logic signed [31:0] s, d, t;
        logic signed [31:0] z [ORDER_MAX];
        n = order_in_use();
        for (int i = 0; i < n; i++) begin
            s = 0;
            for (int k = 0; k < i; k++) s = clamp32(longint'(s) + fx_mul(mat_model[i][k], mat_model[i][k]));
            if (mat_model[i][i] < s) begin
                push_result(i, 0, RES_NPD, 1'b1);
                return;
            end
            d = fx_sqrt(clamp32(longint'(mat_model[i][i]) - s));
            if (d == 0) begin
                push_result(i, 0, RES_ZERO_PIVOT, 1'b1);
                return;
            end
            mat_model[i][i] = d;
            for (int j = i + 1; j < n; j++) begin
                s = 0;
                for (int k = 0; k < i; k++)
                    s = clamp32(longint'(s) + fx_mul(mat_model[j][k], mat_model[i][k]));
                mat_model[j][i] = fx_div(clamp32(longint'(mat_model[j][i]) - s), d);
            end
        end
        for (int i = 0; i < n; i++) begin
            t = vec_model[i];
            for (int j = 0; j < i; j++) t = clamp32(longint'(t) - fx_mul(mat_model[i][j], z[j]));
            z[i] = fx_div(t, mat_model[i][i]);
        end
        for (int i = n - 1; i >= 0; i--) begin
            t = z[i];
            for (int j = i + 1; j < n; j++) t = clamp32(longint'(t) - fx_mul(mat_model[j][i], z[j]));
            z[i] = fx_div(t, mat_model[i][i]);
        end
        for (int i = 0; i < n; i++) push_result(i, z[i], RES_OK, i == n - 1);
    endfunction

    function automatic void apply_item(logic [1:0] kind, logic [3:0] row, logic [3:0] col,
                                       logic signed [31:0] value);
        case (kind)
            KIND_MATRIX: mat_model[row][col] = value;
            KIND_VECTOR: vec_model[row] = value;
            KIND_SOLVE: begin
                solves_sent++;
                predict_solution();
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(logic [1:0] kind, logic [3:0] row, logic [3:0] col,
                             logic signed [31:0] value);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {value, col, row};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        apply_item(kind, row, col, value);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_solutions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_order(logic [4:0] n);
        wait_drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= n;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        order_reg = n;
    endtask

    // diagonally dominant system, matrix cells loaded in shuffled order
    task automatic load_system(int n, bit wild_rhs);
        int cells [$];
        int a, tmp;
        logic signed [31:0] v;
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= r; c++) cells.push_back(r * ORDER_MAX + c);
        for (int i = cells.size() - 1; i > 0; i--) begin
            a = $urandom_range(i);
            tmp = cells[i];
            cells[i] = cells[a];
            cells[a] = tmp;
        end
        foreach (cells[i]) begin
            if (cells[i] / ORDER_MAX == cells[i] % ORDER_MAX)
                v = n * Q_ONE + $urandom_range(4 * Q_ONE);
            else
                v = $signed($urandom_range(Q_ONE)) - 32'sd32768;
            send_item(KIND_MATRIX, cells[i] / ORDER_MAX, cells[i] % ORDER_MAX, v);
        end
        for (int r = 0; r < n; r++) begin
            v = wild_rhs ? $signed($urandom()) : $signed($urandom_range(8 * Q_ONE)) - 4 * Q_ONE;
            send_item(KIND_VECTOR, r, 0, v);
        end
    endtask

    task automatic test_directed();
        set_order(5'd1);
        // saturating divide: tiny pivot with a large right-hand side
        send_item(KIND_MATRIX, 0, 0, 32'sh0000_0100);
        send_item(KIND_VECTOR, 0, 0, Q_MAX);
        send_item(KIND_SOLVE, 0, 0, 0);
        send_item(KIND_VECTOR, 0, 0, Q_MIN);
        send_item(KIND_MATRIX, 0, 0, Q_MAX);
        send_item(KIND_SOLVE, 0, 0, 0);
        // zero pivot, negative diagonal
        send_item(KIND_MATRIX, 0, 0, 0);
        send_item(KIND_SOLVE, 0, 0, 0);
        send_item(KIND_MATRIX, 0, 0, Q_MIN);
        send_item(KIND_SOLVE, 0, 0, 0);
        // unused kind and far corners of the store
        send_item(KIND_UNUSED, 4'hF, 4'hF, Q_MAX);
        send_item(KIND_MATRIX, 4'hF, 4'hF, Q_MAX);
        send_item(KIND_MATRIX, 4'h0, 4'hF, Q_MIN);
        send_item(KIND_VECTOR, 4'hF, 4'h5, $signed(32'hA5A5_5A5A));
        // order 0 acts as 1
        set_order(5'd0);
        send_item(KIND_MATRIX, 0, 0, 4 * Q_ONE);
        send_item(KIND_VECTOR, 0, 0, Q_ONE);
        send_item(KIND_SOLVE, 0, 0, 0);
        // order 3, then a repeated solve on the stored factor
        set_order(5'd3);
        load_system(3, 1'b0);
        send_item(KIND_SOLVE, 0, 0, 0);
        send_item(KIND_SOLVE, 0, 0, 0);
    endtask

    task automatic test_random_phase(int gap, int stall, int quota);
        int n;
        int stop_at;
        stop_at = items_sent + quota;
        send_gap_pct = gap;
        stall_pct = stall;
        while (items_sent < stop_at) begin
            n = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 5);
            case ($urandom_range(3))
                0: set_order(n[4:0]);
                1: set_order(n[4:0] | 5'd0);
                2: set_order(n[4:0]);
                default: set_order(($urandom_range(1) != 0) ? 5'd31 : 5'd17);
            endcase
            n = order_in_use();
            if (n == ORDER_MAX) set_order(5'd4);
            n = order_in_use();
            load_system(n, $urandom_range(3) == 0);
            if ($urandom_range(3) == 0) send_item(KIND_UNUSED, $urandom(), $urandom(), $urandom());
            if ($urandom_range(4) == 0)
                send_item(KIND_MATRIX, $urandom_range(n - 1), $urandom_range(n - 1), $urandom());
            if ($urandom_range(4) == 0) begin
                // break the diagonal of a random row
                n = $urandom_range(order_in_use() - 1);
                send_item(KIND_MATRIX, n, n, ($urandom_range(1) != 0) ? 0 : -Q_ONE);
            end
            send_item(KIND_SOLVE, $urandom(), $urandom(), $urandom());
            if ($urandom_range(5) == 0) send_item(KIND_SOLVE, 0, 0, 0);
        end
    endtask

    task automatic test_backpressure();
        send_gap_pct = 0;
        stall_pct = 0;
        // order above the store size clamps to the full order
        set_order(5'd31);
        load_system(16, 1'b1);
        fork
            begin
                hold_output = 1'b1;
                repeat (20000) @(posedge aclk);
                hold_output = 1'b0;
            end
        join_none
        send_item(KIND_SOLVE, 0, 0, 0);
        send_item(KIND_VECTOR, 4'hF, 0, Q_ONE);
        send_item(KIND_UNUSED, 0, 0, 0);
        wait_drain();
    endtask

    always @(posedge aclk) begin
        m_tready <= !hold_output && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("cholesky_linear_solver_unit_tb failed");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        sol_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_solutions.size() == 0) begin
                $error("unexpected result index %0d", m_tdata[3:0]);
                fail_count++;
            end else begin
                exp_r = pending_solutions.pop_front();
                if (exp_r.status != RES_OK) error_results++;
                if (m_tdata[3:0] != exp_r.index) begin
                    $error("index: expected %0d, got %0d", exp_r.index, m_tdata[3:0]);
                    fail_count++;
                end
                if ($signed(m_tdata[35:4]) != exp_r.solution) begin
                    $error("solution: expected %0d, got %0d", exp_r.solution,
                           $signed(m_tdata[35:4]));
                    fail_count++;
                end
                if (m_tuser != exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
                    fail_count++;
                end
                if (m_tlast != exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        for (int r = 0; r < ORDER_MAX; r++) begin
            vec_model[r] = 0;
            for (int c = 0; c < ORDER_MAX; c++) mat_model[r][c] = 0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(0, 0, 25);
        test_random_phase(68, 0, 25);
        test_random_phase(0, 68, 25);
        test_random_phase(15, 15, 25);
        test_backpressure();
        test_random_phase(15, 15, ITEM_TARGET - items_sent);
        wait_drain();
        if (pending_solutions.size() != 0) begin
            $error("%0d results never arrived", pending_solutions.size());
            fail_count++;
        end
        $display("covered %0d items, %0d solves, %0d results (%0d error reports)",
                 items_sent, solves_sent, results_seen, error_results);
        $display("orders 0..31 incl. clamped, idle/stall phases and a long output hold");
        if (fail_count == 0) begin
            $display("cholesky_linear_solver_unit_tb passed");
        end else begin
            $display("cholesky_linear_solver_unit_tb failed");
        end
        $finish;
    end

endmodule
